>>> src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Constants and round functions shared by the AES-128 encryption pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned HALF_W    = 64;
   localparam int unsigned BLOCK_W   = 128;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned NUM_ROUND = 10;
   localparam int unsigned CSR_IDX_W = 1;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_KEY_HIGH = 1'd0;
   localparam csr_idx_type CSR_KEY_LOW  = 1'd1;

   localparam logic [8*NUM_ROUND-1:0] RCON_ROM = 80'h01_02_04_08_10_20_40_80_1b_36;

   localparam logic [2047:0] SBOX_ROM = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] sbox(input logic [7:0] a);
      return SBOX_ROM[{~a, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [3:0] idx;
      idx = 4'(NUM_ROUND) - r;
      return RCON_ROM[{idx, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] get_byte(input block_type s, input int n);
      return s[BLOCK_W-1-8*n -: 8];
   endfunction

   // Next round key from the previous one and the round number 1 to 10.
   function automatic block_type next_key(input block_type k, input logic [3:0] r);
      word_type w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BLOCK_W-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[BLOCK_W-1-32*c -: 32] = {
            xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
      return t;
   endfunction

endpackage

>>> src/aes_req_if.sv
// ----------------------------------------------------------------------------
// AES request channel
// Plaintext block with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aes_req_if;
   logic                       valid;
   logic                       ready;
   logic [aes_pkg::HALF_W-1:0] plain_high;
   logic [aes_pkg::HALF_W-1:0] plain_low;

   modport source (output valid, output plain_high, output plain_low, input ready);
   modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

>>> src/aes_rsp_if.sv
// ----------------------------------------------------------------------------
// AES response channel
// Ciphertext block with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aes_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [aes_pkg::HALF_W-1:0] cipher_high;
   logic [aes_pkg::HALF_W-1:0] cipher_low;

   modport source (output valid, output cipher_high, output cipher_low, input ready);
   modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

>>> src/aes_csr_if.sv
// ----------------------------------------------------------------------------
// AES configuration channel
// Register write beats with index and data.
// ----------------------------------------------------------------------------
interface aes_csr_if;
   logic                          valid;
   logic                          ready;
   logic [aes_pkg::CSR_IDX_W-1:0] index;
   logic [aes_pkg::HALF_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Eleven-stage pipeline: initial key XOR, then one round and one key step per stage.
// ----------------------------------------------------------------------------
// An accepted request beat passes through every stage register in order before it leaves as its response beat.
// Throughput is one block per cycle unless a response stalls; each round stage holds one round and its key step.
// A stalled response holds the whole pipeline without losing any beat.
// Reset clears all stage valid bits and both key registers to zero.
module aes128_block_encrypt (
   input  logic      clock,
   input  logic      reset,
   aes_req_if.sink   req_ch,
   aes_rsp_if.source rsp_ch,
   aes_csr_if.sink   csr_ch
);

   localparam int unsigned NS = aes_pkg::NUM_ROUND + 1;

   logic [aes_pkg::HALF_W-1:0] key_high_ff, key_low_ff;
   aes_pkg::block_type         state_ff [NS];
   aes_pkg::block_type         rkey_ff  [NS-1];
   logic [NS-1:0]              vld_ff;
   logic                       adv;

   assign adv          = !vld_ff[NS-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            aes_pkg::CSR_KEY_HIGH: key_high_ff <= csr_ch.data;
            aes_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff[0] <= {req_ch.plain_high, req_ch.plain_low} ^ {key_high_ff, key_low_ff};
         rkey_ff[0]  <= {key_high_ff, key_low_ff};
      end
   end

   for (genvar r = 1; r < NS; r++) begin : g_round
      aes_pkg::block_type key_in, sub_in, state_in;
      always_comb begin
         key_in = aes_pkg::next_key(rkey_ff[r-1], 4'(r));
         sub_in = aes_pkg::sub_shift(state_ff[r-1]);
         if (r == NS - 1) begin
            state_in = sub_in ^ key_in;
         end else begin
            state_in = aes_pkg::mix_columns(sub_in) ^ key_in;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            state_ff[r] <= state_in;
         end
      end
      if (r < NS - 1) begin : g_key
         always_ff @(posedge clock) begin
            if (adv) begin
               rkey_ff[r] <= key_in;
            end
         end
      end
   end

   assign rsp_ch.valid       = vld_ff[NS-1];
   assign rsp_ch.cipher_high = state_ff[NS-1][aes_pkg::BLOCK_W-1:aes_pkg::HALF_W];
   assign rsp_ch.cipher_low  = state_ff[NS-1][aes_pkg::HALF_W-1:0];

endmodule
